// ----- hw/rtl/lottery_ticket_scheduler_core_defines.svh -----
// Assertion macros for the lottery ticket scheduler
`ifndef LOTTERY_TICKET_SCHEDULER_CORE_DEFINES_SVH
`define LOTTERY_TICKET_SCHEDULER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted
`define LTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define LTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LTS_ASSERT(label, prop, msg)
`define LTS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- hw/rtl/lts_pkg.sv -----
// Shared widths, codes and state type of the lottery ticket scheduler
package lts_pkg;

  localparam int OWNER_W  = 8;
  localparam int TICKET_W = 16;
  localparam int RAND_W   = 32;
  localparam int STATUS_W = 2;
  localparam int BIT_W    = $clog2(RAND_W);
  localparam int ENTRY_W  = TICKET_W + OWNER_W;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd3;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_DIVIDE = 6'b000100,
    S_READ   = 6'b001000,
    S_LOAD   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

endpackage

// ----- hw/rtl/lts_if.sv -----
// Request and result channel interfaces of the lottery ticket scheduler
interface lts_in_if import lts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [OWNER_W-1:0]  owner_id;
  logic [TICKET_W-1:0] ticket;
  logic [RAND_W-1:0]   random_word;

  modport source (output valid, operation, owner_id, ticket, random_word, input ready);
  modport sink   (input valid, operation, owner_id, ticket, random_word, output ready);
endinterface

interface lts_out_if import lts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TICKET_W-1:0] winning_ticket;
  logic [OWNER_W-1:0]  winner_id;

  modport source (output valid, status, winning_ticket, winner_id, input ready);
  modport sink   (input valid, status, winning_ticket, winner_id, output ready);
endinterface

// ----- hw/rtl/lts_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module lts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hw/rtl/lottery_ticket_scheduler_core.sv -----
// Top level of the lottery ticket scheduler: sequencer around the ticket RAM
//
// in_i carries requests: operation 0 allocates ticket to owner_id, operation 1
// draws a winner using random_word. out_o returns exactly one result per
// request: status, and on a successful draw the winning ticket and owner.
// Tickets and owners live in one RAM, TABLE_DEPTH entries of {ticket, owner}.
// One request is worked on at a time; in_i.ready is high while the sequencer
// is idle, also while a finished result still waits in the output register.
// Allocate: the duplicate search reads one stored entry per cycle from the
// RAM. Draw: random_word mod count is found by a restoring divider, one
// quotient bit per cycle, then one RAM read; on an empty table the draw
// returns the empty status without dividing. The next request is accepted
// in the cycle after the result is loaded.
// A stalled receiver holds the result in the output register; the
// next request may be accepted and worked on, and its result waits until
// the register frees. Reset empties the table (count to zero) and clears
// pending results; no clearing pass over the RAM is needed.
`include "lottery_ticket_scheduler_core_defines.svh"

module lottery_ticket_scheduler_core import lts_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  lts_in_if.sink    in_i,
  lts_out_if.source out_o
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    issue_q, issue_d;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic [OWNER_W-1:0]  owner_q, owner_d;
  logic [TICKET_W-1:0] ticket_q, ticket_d;
  logic [RAND_W-1:0]   rand_q, rand_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [TICKET_W-1:0] res_ticket_q, res_ticket_d;
  logic [OWNER_W-1:0]  res_owner_q, res_owner_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [TICKET_W-1:0] out_ticket_q, out_ticket_d;
  logic [OWNER_W-1:0]  out_owner_q, out_owner_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               hit;
  logic [CNT_W:0]     div_t;
  logic               div_ge;
  logic [CNT_W-1:0]   div_r;

  lts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i ({ticket_q, owner_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Compare of the entry read in the previous search cycle
  assign hit = pend_q && (ram_rdata[ENTRY_W-1:OWNER_W] == ticket_q);

  // One restoring division step: shift in the next dividend bit
  assign div_t  = {rem_q, rand_q[RAND_W-1]};
  assign div_ge = div_t >= {1'b0, count_q};
  assign div_r  = div_ge ? CNT_W'(div_t - {1'b0, count_q}) : div_t[CNT_W-1:0];

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.winning_ticket = out_ticket_q;
  assign out_o.winner_id      = out_owner_q;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    issue_d      = issue_q;
    pend_d       = 1'b0;
    owner_d      = owner_q;
    ticket_d     = ticket_q;
    rand_d       = rand_q;
    rem_d        = rem_q;
    bit_d        = bit_q;
    res_status_d = res_status_q;
    res_ticket_d = res_ticket_q;
    res_owner_d  = res_owner_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_ticket_d = out_ticket_q;
    out_owner_d  = out_owner_q;
    ram_we       = 1'b0;
    ram_raddr    = issue_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          owner_d      = in_i.owner_id;
          ticket_d     = in_i.ticket;
          rand_d       = in_i.random_word;
          issue_d      = '0;
          rem_d        = '0;
          bit_d        = '0;
          res_ticket_d = '0;
          res_owner_d  = '0;
          if (in_i.operation == OP_ALLOC) begin
            state_d = S_SEARCH;
          end else if (count_q == '0) begin
            res_status_d = STS_EMPTY;
            state_d      = S_DONE;
          end else begin
            state_d = S_DIVIDE;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          res_status_d = STS_DUP;
          state_d      = S_DONE;
        end else if (issue_q != count_q) begin
          // read the next stored entry
          issue_d = issue_q + 1'b1;
          pend_d  = 1'b1;
        end else if (count_q == FULL_CNT) begin
          res_status_d = STS_FULL;
          state_d      = S_DONE;
        end else begin
          // no duplicate: append at the end of the table
          ram_we       = 1'b1;
          count_d      = count_q + 1'b1;
          res_status_d = STS_OK;
          state_d      = S_DONE;
        end
      end
      S_DIVIDE: begin
        rem_d  = div_r;
        rand_d = rand_q << 1;
        bit_d  = bit_q + 1'b1;
        if (bit_q == BIT_W'(RAND_W - 1)) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        ram_raddr = rem_q[IDX_W-1:0];
        state_d   = S_LOAD;
      end
      S_LOAD: begin
        res_status_d = STS_OK;
        res_ticket_d = ram_rdata[ENTRY_W-1:OWNER_W];
        res_owner_d  = ram_rdata[OWNER_W-1:0];
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_ticket_d = res_ticket_q;
          out_owner_d  = res_owner_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    owner_q      <= owner_d;
    ticket_q     <= ticket_d;
    rand_q       <= rand_d;
    rem_q        <= rem_d;
    bit_q        <= bit_d;
    res_status_q <= res_status_d;
    res_ticket_q <= res_ticket_d;
    res_owner_q  <= res_owner_d;
    out_status_q <= out_status_d;
    out_ticket_q <= out_ticket_d;
    out_owner_q  <= out_owner_d;
  end

  // Checks
  `LTS_ASSERT_ALWAYS(a_count_bound, !rst_ni || (count_q <= FULL_CNT), "ticket count above table depth")
  `LTS_ASSERT(a_write_not_full, ram_we |-> (count_q != FULL_CNT), "write into a full table")
  `LTS_ASSERT(a_count_step, ram_we |=> (count_q == $past(count_q) + 1'b1), "count not stepped on append")
  `LTS_ASSERT(a_search_bound, (pend_q && state_q == S_SEARCH) |-> (issue_q <= count_q), "search beyond stored entries")

endmodule

// ----- verif/lts_result_check.sv -----
// Result checker for the lottery ticket scheduler: ticket table prediction and result compare
module lts_result_check import lts_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lts_in_if           req_i,
  lts_out_if          res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TICKET_W-1:0] ticket;
    logic [OWNER_W-1:0]  owner;
  } outcome_t;

  // Shadow of the ticket table
  logic [TICKET_W-1:0] ticket_tab [TABLE_DEPTH];
  logic [OWNER_W-1:0]  owner_tab  [TABLE_DEPTH];
  int unsigned         held_count;

  // Outcomes of accepted requests, oldest first
  outcome_t    awaited_results [$];
  int unsigned failures = 0;

  // Outcome of one request; an accepted allocate also updates the table
  function automatic outcome_t lottery_outcome(input logic                op,
                                               input logic [OWNER_W-1:0]  owner,
                                               input logic [TICKET_W-1:0] tk,
                                               input logic [RAND_W-1:0]   word);
    outcome_t    res;
    bit          dup;
    int unsigned pick;
    res = '0;
    dup = 1'b0;
    if (op == OP_ALLOC) begin
      for (int unsigned i = 0; i < held_count; i++) begin
        if (ticket_tab[i] == tk) dup = 1'b1;
      end
      // duplicate wins over full
      if (dup) begin
        res.status = STS_DUP;
      end else if (held_count >= TABLE_DEPTH) begin
        res.status = STS_FULL;
      end else begin
        ticket_tab[held_count] = tk;
        owner_tab[held_count]  = owner;
        held_count++;
        res.status = STS_OK;
      end
    end else if (held_count == 0) begin
      res.status = STS_EMPTY;
    end else begin
      pick       = word % held_count;
      res.status = STS_OK;
      res.ticket = ticket_tab[pick];
      res.owner  = owner_tab[pick];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      awaited_results.delete();
      held_count = 0;
      pending_o    <= 0;
      fail_count_o <= failures;
    end else begin
      // results always belong to requests accepted on earlier edges
      if (res_i.valid && res_i.ready) begin
        if (awaited_results.size() == 0) begin
          if (failures < REPORT_LIMIT)
            $display("unexpected result: status %0d ticket %h owner %h",
                     res_i.status, res_i.winning_ticket, res_i.winner_id);
          failures++;
        end else begin
          want = awaited_results.pop_front();
          if (res_i.status !== want.status || res_i.winning_ticket !== want.ticket ||
              res_i.winner_id !== want.owner) begin
            if (failures < REPORT_LIMIT)
              $display("mismatch: expected status %0d ticket %h owner %h, got %0d %h %h",
                       want.status, want.ticket, want.owner,
                       res_i.status, res_i.winning_ticket, res_i.winner_id);
            failures++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        awaited_results.insert(awaited_results.size(),
                               lottery_outcome(req_i.operation, req_i.owner_id,
                                               req_i.ticket, req_i.random_word));
      pending_o    <= awaited_results.size();
      fail_count_o <= failures;
    end
  end

endmodule

// ----- verif/lottery_ticket_scheduler_core_tb.sv -----
// Testbench top for the lottery ticket scheduler: clock, reset, request stimulus, verdict
module lottery_ticket_scheduler_core_tb import lts_pkg::*; ();

  localparam int TABLE_DEPTH   = 64;
  localparam int RANDOM_ITEMS  = 1035;
  localparam int IDLE_PCT      = 22;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 80;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned fail_count;
  int unsigned pending_count;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req   = 1'b0;

  // tickets sent in allocate requests, to aim duplicates at
  logic [TICKET_W-1:0] issued_tickets [$];

  lts_in_if  req_if ();
  lts_out_if res_if ();

  always #1 clk_i = ~clk_i;

  lottery_ticket_scheduler_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  lts_result_check #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_i       (res_if),
    .fail_count_o(fail_count),
    .pending_o   (pending_count)
  );

  // Present one request and hold it until accepted
  task automatic offer_request(input logic                op,
                               input logic [OWNER_W-1:0]  owner,
                               input logic [TICKET_W-1:0] tk,
                               input logic [RAND_W-1:0]   word);
    if (tx_idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.owner_id    <= owner;
    req_if.ticket      <= tk;
    req_if.random_word <= word;
    if (op == OP_ALLOC) issued_tickets.insert(issued_tickets.size(), tk);
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Random request: allocates dominate early so the table fills, draws later
  task automatic random_request(input int n);
    int unsigned         alloc_pct;
    logic [TICKET_W-1:0] tk;
    logic [RAND_W-1:0]   word;
    alloc_pct = (n < 300) ? 60 : 30;
    if ($urandom_range(99) < alloc_pct) begin
      if (issued_tickets.size() != 0 && $urandom_range(99) < 25)
        tk = issued_tickets[$urandom_range(issued_tickets.size() - 1)];
      else
        tk = TICKET_W'($urandom);
      offer_request(OP_ALLOC, OWNER_W'($urandom), tk, $urandom);
    end else begin
      case ($urandom_range(9))
        0:       word = '0;
        1:       word = '1;
        2:       word = $urandom_range(127);
        default: word = $urandom;
      endcase
      offer_request(OP_DRAW, OWNER_W'($urandom), TICKET_W'($urandom), word);
    end
  endtask

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        res_if.ready <= rx_idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    req_if.valid       <= 1'b0;
    req_if.operation   <= OP_ALLOC;
    req_if.owner_id    <= '0;
    req_if.ticket      <= '0;
    req_if.random_word <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table draws, then smallest and largest tickets and owners
    offer_request(OP_DRAW,  8'h00, 16'h0000, 32'h0000_0000);
    offer_request(OP_DRAW,  8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    offer_request(OP_ALLOC, 8'h00, 16'h0000, 32'hFFFF_FFFF);
    offer_request(OP_ALLOC, 8'hFF, 16'hFFFF, 32'h0000_0000);
    offer_request(OP_ALLOC, 8'hAA, 16'h0000, 32'h0000_0000);
    offer_request(OP_DRAW,  8'h00, 16'h0000, 32'h0000_0000);
    offer_request(OP_DRAW,  8'h00, 16'h0000, 32'hFFFF_FFFF);
    offer_request(OP_ALLOC, 8'h01, 16'h8000, 32'h0000_0000);
    offer_request(OP_DRAW,  8'h55, 16'h5555, 32'h0000_0005);
    offer_request(OP_ALLOC, 8'h00, 16'hFFFF, 32'h0000_0000);
    offer_request(OP_DRAW,  8'hFF, 16'hFFFF, 32'h8000_0000);
    offer_request(OP_ALLOC, 8'h80, 16'h7FFF, 32'h1234_5678);
    offer_request(OP_DRAW,  8'h00, 16'h0000, 32'h0000_0003);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) hold_req = 1'b1;
      // long stretch with both sides streaming
      tx_idle_on = !(n >= 450 && n < 650);
      rx_idle_on = tx_idle_on;
      random_request(n);
    end
    req_if.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lts_pkg.sv
hw/rtl/lts_if.sv
hw/rtl/lts_ram.sv
hw/rtl/lottery_ticket_scheduler_core.sv
verif/lts_result_check.sv
verif/lottery_ticket_scheduler_core_tb.sv
